FILE: design/cop_pkg.sv
// ----------------------------------------------------------------------------
// cop_pkg
// Shared types and constants of the clique overlap pruning block.
// ----------------------------------------------------------------------------
package cop_pkg;

  localparam int NODE_W    = 16;  // node identifier width
  localparam int COV_W     = 8;   // coverage counter width
  localparam int THR_W     = 17;  // overlap threshold width
  localparam int FRAC_W    = 16;  // fraction bits of the threshold (65536 is 1.0)
  localparam int CNT_OUT_W = 9;   // reported count width
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 17;

  localparam logic [COV_W-1:0] COV_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_COVERAGE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_THRESH = 1'd1;

  localparam logic [COV_W-1:0] REQ_COVERAGE_RESET = 8'd1;
  localparam logic [THR_W-1:0] OVERLAP_RESET      = 17'd49152;

  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic              last_node;
  } in_item_t;

  typedef struct packed {
    logic                 keep;
    logic [CNT_OUT_W-1:0] clique_size;
    logic [CNT_OUT_W-1:0] already_taken;
    logic                 overflow;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] wdata;
  } cfg_item_t;

endpackage

FILE: design/cop_stream_if.sv
// ----------------------------------------------------------------------------
// cop_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface cop_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/cop_cov_table.sv
// ----------------------------------------------------------------------------
// cop_cov_table
// Coverage counter memory with one registered read port, one write port and
// a clearing sweep that runs once after reset.
// ----------------------------------------------------------------------------
module cop_cov_table
  import cop_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [COV_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [COV_W-1:0] wr_data,
  output logic             clr_busy
);

  logic [COV_W-1:0] mem [DEPTH];
  logic [AW-1:0]    clr_idx_r;
  logic             clr_busy_r;
  logic [COV_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

FILE: design/clique_overlap_pruning.sv
// ----------------------------------------------------------------------------
// clique_overlap_pruning
// Buffers the nodes of each clique, counts those already covered and either
// discards the clique or increments the coverage counters of its nodes.
// ----------------------------------------------------------------------------
// Each node item is accepted with a coverage memory read, and the taken
// check on the read data follows in the lookup state after it.
// After the last node's check the result is formed in the product state, then
// in the decision state, which waits for the output; a kept clique then walks its
// buffer, 1 node a cycle. No node is accepted during each lookup state.
// After reset the coverage table clears all NODE_COUNT entries and the input
// opens after the clear state ends; configuration writes are taken throughout.
module clique_overlap_pruning
  import cop_pkg::*;
#(
  parameter int NODE_COUNT       = 65536,
  parameter int MAX_CLIQUE_NODES = 256
) (
  input logic clk,
  input logic rst_n,
  cop_stream_if.sink   in_chan,
  cop_stream_if.source out_chan,
  cop_stream_if.sink   cfg_chan
);

  localparam int AW       = $clog2(NODE_COUNT);
  localparam int BW       = $clog2(MAX_CLIQUE_NODES);
  localparam int CW       = $clog2(MAX_CLIQUE_NODES + 1);
  localparam int PW       = THR_W + CW;
  localparam int ID_EXT_W = 25;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOOKUP = 3'd2;
  localparam logic [2:0] ST_MULT   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_WALK   = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic [COV_W-1:0] req_cov_r;
  logic [THR_W-1:0] thr_r;

  logic [CW-1:0]  buf_cnt_r;
  logic [CW-1:0]  taken_cnt_r;
  logic           ovf_r;
  logic           take_r;
  logic           last_r;
  logic [PW-1:0]  prod_r;

  logic [NODE_W-1:0] buf_mem [MAX_CLIQUE_NODES];
  logic [NODE_W-1:0] buf_rd_r;
  logic [CW-1:0]     walk_idx_r;
  logic              s1_r, s2_r;
  logic [AW-1:0]     s2_addr_r;
  logic              fwd_v_r;
  logic [AW-1:0]     fwd_addr_r;
  logic [COV_W-1:0]  fwd_val_r;

  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              in_acc, cfg_acc;
  logic [ID_EXT_W-1:0] node_ext, buf_ext;
  logic              in_range, room, buf_we;
  logic              issue, walk_done, dec_go, keep;
  logic [PW-1:0]     lhs;
  logic [CW+CNT_OUT_W-1:0] size_ext, taken_ext;

  logic              cov_rd_en, cov_wr_en, cov_clr_busy;
  logic [AW-1:0]     cov_rd_addr;
  logic [COV_W-1:0]  cov_rd_data, cov_cur, cov_wr_data;

  // --------------------------------------------------------------------------
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign cfg_acc = cfg_chan.valid;

  assign node_ext = ID_EXT_W'(in_chan.data.node_id);
  assign buf_ext  = ID_EXT_W'(buf_rd_r);
  assign in_range = node_ext < ID_EXT_W'(NODE_COUNT);
  assign room     = buf_cnt_r < CW'(MAX_CLIQUE_NODES);
  assign buf_we   = in_acc && in_range && room;

  assign issue     = (state_r == ST_WALK) && (walk_idx_r < buf_cnt_r);
  assign walk_done = (state_r == ST_WALK) && !issue && !s1_r && !s2_r;

  assign lhs    = {1'b0, taken_cnt_r, FRAC_W'(0)};
  assign keep   = !(lhs >= prod_r);
  assign dec_go = !out_valid_r || out_chan.ready;

  assign size_ext  = (CW + CNT_OUT_W)'(buf_cnt_r);
  assign taken_ext = (CW + CNT_OUT_W)'(taken_cnt_r);

  // Coverage memory port selection: lookups while streaming, walk otherwise.
  always_comb begin
    if (state_r == ST_WALK) begin
      cov_rd_en   = s1_r;
      cov_rd_addr = buf_ext[AW-1:0];
    end else begin
      cov_rd_en   = in_acc && in_range;
      cov_rd_addr = node_ext[AW-1:0];
    end
  end

  // The write of the previous walk node has not reached the read data yet.
  assign cov_cur     = (fwd_v_r && fwd_addr_r == s2_addr_r) ? fwd_val_r : cov_rd_data;
  assign cov_wr_en   = s2_r && (cov_cur != COV_MAX);
  assign cov_wr_data = cov_cur + 1'b1;

  cop_cov_table #(
    .DEPTH (NODE_COUNT),
    .AW    (AW)
  ) u_cov (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (cov_rd_en),
    .rd_addr  (cov_rd_addr),
    .rd_data  (cov_rd_data),
    .wr_en    (cov_wr_en),
    .wr_addr  (s2_addr_r),
    .wr_data  (cov_wr_data),
    .clr_busy (cov_clr_busy)
  );

  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (!cov_clr_busy) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_acc) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = last_r ? ST_MULT : ST_IDLE;
      ST_MULT:   state_nxt = ST_DECIDE;
      ST_DECIDE: if (dec_go) state_nxt = keep ? ST_WALK : ST_IDLE;
      ST_WALK:   if (walk_done) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      req_cov_r   <= REQ_COVERAGE_RESET;
      thr_r       <= OVERLAP_RESET;
      buf_cnt_r   <= '0;
      taken_cnt_r <= '0;
      ovf_r       <= 1'b0;
      take_r      <= 1'b0;
      last_r      <= 1'b0;
      walk_idx_r  <= '0;
      s1_r        <= 1'b0;
      s2_r        <= 1'b0;
      fwd_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_acc) begin
        case (cfg_chan.data.index)
          CFG_REQ_COVERAGE:   req_cov_r <= cfg_chan.data.wdata[COV_W-1:0];
          CFG_OVERLAP_THRESH: thr_r     <= cfg_chan.data.wdata[THR_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        take_r <= in_range && room;
        last_r <= in_chan.data.last_node;
        if (buf_we) begin
          buf_cnt_r <= buf_cnt_r + 1'b1;
        end
        if (in_range && !room) begin
          ovf_r <= 1'b1;
        end
      end

      if (state_r == ST_LOOKUP && take_r && cov_rd_data > req_cov_r) begin
        taken_cnt_r <= taken_cnt_r + 1'b1;
      end

      // Walk pipeline: buffer read, coverage read, increment and write back.
      s1_r <= issue;
      s2_r <= s1_r;
      fwd_v_r <= s2_r;
      if (issue) begin
        walk_idx_r <= walk_idx_r + 1'b1;
      end

      if ((state_r == ST_DECIDE && dec_go && !keep) || walk_done) begin
        buf_cnt_r   <= '0;
        taken_cnt_r <= '0;
        ovf_r       <= 1'b0;
        walk_idx_r  <= '0;
      end

      if (state_r == ST_DECIDE && dec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[buf_cnt_r[BW-1:0]] <= in_chan.data.node_id;
    end
    buf_rd_r   <= buf_mem[walk_idx_r[BW-1:0]];
    s2_addr_r  <= buf_ext[AW-1:0];
    fwd_addr_r <= s2_addr_r;
    fwd_val_r  <= cov_wr_en ? cov_wr_data : cov_cur;
    if (state_r == ST_MULT) begin
      prod_r <= {{CW{1'b0}}, thr_r} * {{THR_W{1'b0}}, buf_cnt_r};
    end
    if (state_r == ST_DECIDE && dec_go) begin
      out_item_r.keep          <= keep;
      out_item_r.clique_size   <= size_ext[CNT_OUT_W-1:0];
      out_item_r.already_taken <= taken_ext[CNT_OUT_W-1:0];
      out_item_r.overflow      <= ovf_r;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_item_r;

  // --------------------------------------------------------------------------
  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !cov_clr_busy)
    else $error("input ready during coverage clear");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (buf_cnt_r != '0))
    else $error("walk started on an empty clique");

  a_taken_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    taken_cnt_r <= buf_cnt_r)
    else $error("taken count exceeds buffered count");

  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && dec_go) |=> out_valid_r)
    else $error("decision made without a result item");

  a_walk_only_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && state_nxt == ST_WALK) |=> out_item_r.keep)
    else $error("counters marked for a discarded clique");

endmodule
